### hw/rtl/csti_pkg.sv
// Shared constants for the cross-section table interpolator.
// Register indexes, result region codes and fixed-point widths.
// No dependencies.
package csti_pkg;

    localparam int XS_W   = 32;
    localparam int FRAC_W = 24;
    localparam int FREQ_W = 32;

    // Configuration register indexes
    localparam logic [1:0] REG_STEP    = 2'd0;
    localparam logic [1:0] REG_POINTS  = 2'd1;
    localparam logic [1:0] REG_RATIO   = 2'd2;
    localparam logic [1:0] REG_CLASSIC = 2'd3;

    // Configuration reset values
    localparam logic [15:0] STEP_RST    = 16'd6554;
    localparam logic [7:0]  POINTS_RST  = 8'd100;
    localparam logic [23:0] RATIO_RST   = 24'd655360;
    localparam logic        CLASSIC_RST = 1'b0;

    // Item kinds
    localparam logic MODE_LOAD  = 1'b0;

    // Result regions
    localparam logic [1:0] REGION_BELOW = 2'd0;
    localparam logic [1:0] REGION_TABLE = 2'd1;
    localparam logic [1:0] REGION_TAIL  = 2'd2;
    localparam logic [1:0] REGION_LOAD  = 2'd3;

endpackage

### hw/rtl/cross_section_table_interpolator_top.sv
// Throughput: one item per cycle; the whole pipeline advances unless the output is held.
// The pipeline holds two bit-per-stage dividers (table position and tail ratio).
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
// The table RAM is not cleared; entries are undefined until loaded.
module cross_section_table_interpolator_top #(
    parameter int MAX_POINTS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [6:0]  entry_index,
    input  logic [31:0] entry_value,
    input  logic [31:0] edge_freq,
    input  logic [31:0] query_freq,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] cross_section,
    output logic [1:0]  region
);

    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW   = $clog2(MAX_POINTS + 1);
    localparam int AW   = (PW + 17 > 24) ? PW + 17 : 24;
    localparam int NW   = 32 + AW;
    localparam int DENW = 48;
    localparam int QI   = IW + csti_pkg::FRAC_W;
    localparam int ND   = (QI > 32) ? QI : 32;

    typedef struct packed {
        logic          vld;
        logic          load;
        logic          wr_ok;
        logic [IW-1:0] idx;
        logic [31:0]   val;
        logic          below;
        logic          cin;
        logic          ovf_i;
        logic          ovf_t;
    } ctl_t;

    typedef struct packed {
        logic        vld;
        logic [1:0]  rg;
        logic        use_a;
        logic [23:0] f;
        logic [31:0] q;
    } bk_t;

    // Configuration registers
    logic [15:0]   step_reg;
    logic [7:0]    points_reg;
    logic [23:0]   ratio_reg;
    logic          classic_reg;
    logic [15:0]   sf_eff_reg;
    logic [PW-1:0] p_eff_reg;
    logic [AW-1:0] anchor_c_reg;

    logic [15:0]   sf_eff_next;
    logic [31:0]   p_clamp;
    logic [PW-1:0] p_eff_next;
    logic [AW-1:0] anchor_c_next;

    logic adv;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= csti_pkg::STEP_RST;
            points_reg  <= csti_pkg::POINTS_RST;
            ratio_reg   <= csti_pkg::RATIO_RST;
            classic_reg <= csti_pkg::CLASSIC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csti_pkg::REG_STEP:    step_reg    <= cfg_data[15:0];
                csti_pkg::REG_POINTS:  points_reg  <= cfg_data[7:0];
                csti_pkg::REG_RATIO:   ratio_reg   <= cfg_data;
                csti_pkg::REG_CLASSIC: classic_reg <= cfg_data[0];
                default:               step_reg    <= step_reg;
            endcase
        end
    end

    // Derive effective step, point count and classic anchor
    always_comb
    begin
        sf_eff_next = (step_reg == 16'd0) ? 16'd1 : step_reg;
        p_clamp     = 32'(points_reg);
        if (p_clamp < 32'd2)
        begin
            p_clamp = 32'd2;
        end
        if (p_clamp > 32'(MAX_POINTS))
        begin
            p_clamp = 32'(MAX_POINTS);
        end
        p_eff_next    = PW'(p_clamp);
        anchor_c_next = AW'(32'd65536 + 32'(sf_eff_next) * p_clamp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_eff_reg   <= '0;
            p_eff_reg    <= '0;
            anchor_c_reg <= '0;
        end
        else
        begin
            sf_eff_reg   <= sf_eff_next;
            p_eff_reg    <= p_eff_next;
            anchor_c_reg <= anchor_c_next;
        end
    end

    // Global advance: hold everything while a result waits untaken
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Stage 1: capture the transfer, clamp the edge, flag below-edge
    ctl_t        c1_reg, c1_next;
    logic [31:0] edge1_reg, nu1_reg, d1_reg;
    logic [31:0] edge_e;

    always_comb
    begin
        edge_e       = (edge_freq == 32'd0) ? 32'd1 : edge_freq;
        c1_next      = '0;
        c1_next.vld  = in_valid;
        c1_next.load = (mode == csti_pkg::MODE_LOAD);
        c1_next.wr_ok = (32'(entry_index) < 32'(MAX_POINTS));
        c1_next.idx  = IW'(32'(entry_index));
        c1_next.val  = entry_value;
        c1_next.below = (query_freq < edge_e);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
        end
        else if (adv)
        begin
            c1_reg <= c1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            edge1_reg <= edge_e;
            nu1_reg   <= query_freq;
            d1_reg    <= query_freq - edge_e;
        end
    end

    // Stage 2: multiply edge by step and by the tail anchor
    ctl_t            c2_reg;
    logic [DENW-1:0] den2_reg, num2_reg;
    logic [NW-1:0]   n2_reg;
    logic [31:0]     nu2_reg;
    logic [AW-1:0]   anchor_sel;

    assign anchor_sel = classic_reg ? anchor_c_reg : AW'(ratio_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg <= '0;
        end
        else if (adv)
        begin
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den2_reg <= DENW'(edge1_reg) * DENW'(sf_eff_reg);
            n2_reg   <= NW'(edge1_reg) * NW'(anchor_sel);
            num2_reg <= {d1_reg, 16'd0};
            nu2_reg  <= nu1_reg;
        end
    end

    // Stage 3: range checks and divider setup
    ctl_t            c3_reg, c3_next;
    logic [DENW-1:0] den3_reg, remi3_reg;
    logic [QI-1:0]   lowi3_reg;
    logic [31:0]     nu3_reg, remt3_reg, lowt3_reg;

    always_comb
    begin
        c3_next       = c2_reg;
        c3_next.ovf_i = ({IW'(0), num2_reg} >= {den2_reg, IW'(0)});
        c3_next.ovf_t = (n2_reg >= NW'({nu2_reg, 24'd0}));
        c3_next.cin   = (NW'({nu2_reg, 16'd0}) <= n2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_reg <= '0;
        end
        else if (adv)
        begin
            c3_reg <= c3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den3_reg  <= den2_reg;
            remi3_reg <= num2_reg >> IW;
            lowi3_reg <= {num2_reg[IW-1:0], 24'd0};
            nu3_reg   <= nu2_reg;
            remt3_reg <= 32'(n2_reg >> 24);
            lowt3_reg <= {n2_reg[23:0], 8'd0};
        end
    end

    // Dividers: table position in Q.24 and tail ratio in Q.24
    logic [QI-1:0] quo_i;
    logic [31:0]   quo_t;

    csti_div #(
        .DW  (DENW),
        .QW  (QI),
        .NST (ND)
    ) u_div_pos (
        .clk    (clk),
        .en     (adv),
        .den_in (den3_reg),
        .rem_in (remi3_reg),
        .low_in (lowi3_reg),
        .quo    (quo_i)
    );

    csti_div #(
        .DW  (32),
        .QW  (32),
        .NST (ND)
    ) u_div_tail (
        .clk    (clk),
        .en     (adv),
        .den_in (nu3_reg),
        .rem_in (remt3_reg),
        .low_in (lowt3_reg),
        .quo    (quo_t)
    );

    // Carry control alongside the dividers
    ctl_t cd_reg [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ND; k++)
            begin
                cd_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            cd_reg[0] <= c3_reg;
            for (int k = 1; k < ND; k++)
            begin
                cd_reg[k] <= cd_reg[k-1];
            end
        end
    end

    // Read stage: choose region and table addresses, write loads
    ctl_t          cl;
    bk_t           rd_reg, rd_next;
    logic [IW-1:0] i_sat, addr_a, addr_b;
    logic [PW-1:0] pm1;
    logic          i_lt, tab, interp_tab;
    logic [31:0]   rdata_a, rdata_b;

    assign cl = cd_reg[ND-1];

    always_comb
    begin
        i_sat      = cl.ovf_i ? '1 : quo_i[QI-1:csti_pkg::FRAC_W];
        pm1        = p_eff_reg - PW'(1);
        i_lt       = (32'(i_sat) < 32'(pm1));
        interp_tab = !classic_reg && i_lt;
        tab        = classic_reg ? cl.cin : i_lt;
        if (classic_reg && (32'(i_sat) > 32'(pm1)))
        begin
            addr_a = IW'(pm1);
        end
        else
        begin
            addr_a = i_sat;
        end
        addr_b = interp_tab ? (i_sat + IW'(1)) : IW'(pm1);

        rd_next       = '0;
        rd_next.vld   = cl.vld;
        rd_next.use_a = classic_reg;
        rd_next.f     = quo_i[csti_pkg::FRAC_W-1:0];
        rd_next.q     = cl.ovf_t ? '1 : quo_t;
        if (cl.load)
        begin
            rd_next.rg = csti_pkg::REGION_LOAD;
        end
        else if (cl.below)
        begin
            rd_next.rg = csti_pkg::REGION_BELOW;
        end
        else if (tab)
        begin
            rd_next.rg = csti_pkg::REGION_TABLE;
        end
        else
        begin
            rd_next.rg = csti_pkg::REGION_TAIL;
        end
    end

    csti_ram #(
        .WIDTH (csti_pkg::XS_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk     (clk),
        .we      (adv && cl.vld && cl.load && cl.wr_ok),
        .waddr   (cl.idx),
        .wdata   (cl.val),
        .re      (adv),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
        end
        else if (adv)
        begin
            rd_reg <= rd_next;
        end
    end

    // Multiply 1: interpolation product and first tail factor
    bk_t                m1_reg;
    logic signed [57:0] prod1_reg;
    logic [31:0]        a1_reg, y1_reg;
    logic               sat1_reg;
    logic signed [32:0] diff;
    logic [63:0]        t1;

    assign diff = $signed({1'b0, rdata_b}) - $signed({1'b0, rdata_a});
    assign t1   = 64'(rdata_b) * 64'(rd_reg.q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg <= '0;
        end
        else if (adv)
        begin
            m1_reg <= rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod1_reg <= $signed({1'b0, rd_reg.f}) * diff;
            a1_reg    <= rdata_a;
            y1_reg    <= t1[55:24];
            sat1_reg  <= (t1[63:56] != 8'd0);
        end
    end

    // Multiply 2: finish the blend, second tail factor
    bk_t                m2_reg;
    logic [31:0]        tabv2_reg, y2_reg;
    logic               sat2_reg;
    logic signed [57:0] blend;
    logic [63:0]        t2;

    assign blend = $signed({2'b00, a1_reg, 24'd0}) + prod1_reg + 58'sd8388608;
    assign t2    = 64'(y1_reg) * 64'(m1_reg.q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_reg <= '0;
        end
        else if (adv)
        begin
            m2_reg <= m1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tabv2_reg <= m1_reg.use_a ? a1_reg : blend[55:24];
            y2_reg    <= t2[55:24];
            sat2_reg  <= sat1_reg || (t2[63:56] != 8'd0);
        end
    end

    // Output stage: third tail factor and result select
    logic        out_valid_reg;
    logic [31:0] xs_reg, xs_next;
    logic [1:0]  region_reg;
    logic [63:0] t3;

    assign t3 = 64'(y2_reg) * 64'(m2_reg.q);

    always_comb
    begin
        case (m2_reg.rg)
            csti_pkg::REGION_TABLE: xs_next = tabv2_reg;
            csti_pkg::REGION_TAIL:
            begin
                if (sat2_reg || (t3[63:56] != 8'd0))
                begin
                    xs_next = '1;
                end
                else
                begin
                    xs_next = t3[55:24];
                end
            end
            default:                xs_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m2_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xs_reg     <= xs_next;
            region_reg <= m2_reg.rg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cross_section = xs_reg;
    assign region        = region_reg;

`ifndef ASSERT_OFF
    // Loads and below-edge queries must answer zero
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == csti_pkg::REGION_LOAD) |-> (cross_section == 32'd0))
        else $error("load result not zero");

    a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == csti_pkg::REGION_BELOW) |-> (cross_section == 32'd0))
        else $error("below-edge result not zero");

    // Valid bits must move through the front and the read stage on advance
    a_front_moves: assert property (@(posedge clk) disable iff (!rst_n)
        c1_reg.vld && adv |=> c2_reg.vld)
        else $error("item lost in front stages");

    a_read_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cd_reg[ND-1].vld && adv |=> rd_reg.vld)
        else $error("item lost at table read");
`endif

endmodule

### hw/rtl/csti_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module csti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports, hold while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### hw/rtl/csti_div.sv
// Pipelined restoring divider, one quotient bit per stage in the last QW of NST stages.
// Remainder input must be below the divisor. No dependencies.
module csti_div #(
    parameter int DW  = 32,
    parameter int QW  = 32,
    parameter int NST = 32
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] den_in,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] den_reg [NST];
    logic [DW-1:0] rem_reg [NST];
    logic [QW-1:0] low_reg [NST];
    logic [QW-1:0] quo_reg [NST];

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_stage
            logic [DW-1:0] den_src;
            logic [DW-1:0] rem_src;
            logic [QW-1:0] low_src;
            logic [QW-1:0] quo_src;
            logic [DW:0]   trial;
            logic          ge;
            logic [DW-1:0] rem_next;
            logic [QW-1:0] low_next;
            logic [QW-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign den_src = den_in;
                assign rem_src = rem_in;
                assign low_src = low_in;
                assign quo_src = '0;
            end
            else
            begin : g_rest
                assign den_src = den_reg[k-1];
                assign rem_src = rem_reg[k-1];
                assign low_src = low_reg[k-1];
                assign quo_src = quo_reg[k-1];
            end

            // Shift in the next dividend bit and try a subtract
            assign trial = {rem_src, low_src[QW-1]};
            assign ge    = (trial >= {1'b0, den_src});

            always_comb
            begin
                if (k >= NST - QW)
                begin
                    rem_next = ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
                    low_next = {low_src[QW-2:0], 1'b0};
                    quo_next = {quo_src[QW-2:0], ge};
                end
                else
                begin
                    rem_next = rem_src;
                    low_next = low_src;
                    quo_next = quo_src;
                end
            end

            // Advance the stage
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_src;
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= low_next;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NST-1];

endmodule

### tb/sv/cross_section_table_interpolator_top_tb.sv
// Self-checking testbench for the cross-section table interpolator.
// Loads the table, sweeps register settings and queries against a predictor.
// Depends on csti_pkg and cross_section_table_interpolator_top.
`timescale 1ns / 100ps

module cross_section_table_interpolator_top_tb;

    localparam logic MODE_QUERY  = 1'b1;
    localparam int   TBL_DEPTH   = 128;
    localparam int   QUIET_GAP   = 60;   // longer than it takes the pipeline to drain
    localparam int   CALM_ITEMS  = 150;  // no idling for the last items

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_idx;
        logic [23:0] cfg_val;
        logic        mode;
        logic [6:0]  idx;
        logic [31:0] val;
        logic [31:0] edge_f;
        logic [31:0] nu;
    } xs_item_t;

    typedef struct {
        logic [31:0] xs;
        logic [1:0]  rg;
    } xs_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = csti_pkg::MODE_LOAD;
    logic [6:0]  entry_index = '0;
    logic [31:0] entry_value = '0;
    logic [31:0] edge_freq = 32'd1;
    logic [31:0] query_freq = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] cross_section;
    logic [1:0]  region;

    // Predictor state
    logic [31:0] xs_tbl [TBL_DEPTH];
    logic [15:0] step_q = csti_pkg::STEP_RST;
    logic [7:0]  points_q = csti_pkg::POINTS_RST;
    logic [23:0] ratio_q = csti_pkg::RATIO_RST;
    logic        classic_q = csti_pkg::CLASSIC_RST;

    xs_item_t    pending_items [$];
    xs_result_t  expected_xs [$];
    int          mismatches = 0;
    int          region_hits [4] = '{0, 0, 0, 0};
    int          quiet_cycles = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          in_taken = 1'b0;
    bit          stim_done = 1'b0;

    cross_section_table_interpolator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .entry_index(entry_index), .entry_value(entry_value),
        .edge_freq(edge_freq), .query_freq(query_freq),
        .out_valid(out_valid), .out_ready(out_ready),
        .cross_section(cross_section), .region(region)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Last entry times (edge*anchor/nu)^3, saturating
    function automatic logic [31:0] tail_scale(input longint unsigned anchor,
                                               input longint unsigned edge_v,
                                               input longint unsigned nu_v,
                                               input longint unsigned p);
        longint unsigned n, q, r, y;
        n = edge_v * anchor;
        q = n / nu_v;
        r = n % nu_v;
        for (int b = 0; b < 8; b++)
        begin
            if (q > 64'hFFFF_FFFF) break;
            r = r << 1;
            q = q << 1;
            if (r >= nu_v)
            begin
                r = r - nu_v;
                q = q | 1;
            end
        end
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        y = xs_tbl[p - 1];
        for (int b = 0; b < 3; b++)
        begin
            y = (y * q) >> 24;
            if (y > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        end
        return y[31:0];
    endfunction

    // Compute the result of one transfer and update the table on loads
    function automatic xs_result_t predict_xs(input xs_item_t it);
        xs_result_t res;
        longint unsigned edge_v, nu_v, sf, p, num, den, i, anchor, r, f, a, b;
        res.xs = '0;
        if (it.mode == csti_pkg::MODE_LOAD)
        begin
            xs_tbl[it.idx] = it.val;
            res.rg = csti_pkg::REGION_LOAD;
            return res;
        end
        edge_v = (it.edge_f == 0) ? 1 : it.edge_f;
        nu_v = it.nu;
        sf = (step_q == 0) ? 1 : step_q;
        p = points_q;
        if (p < 2) p = 2;
        if (p > TBL_DEPTH) p = TBL_DEPTH;
        if (nu_v < edge_v)
        begin
            res.rg = csti_pkg::REGION_BELOW;
            return res;
        end
        num = (nu_v - edge_v) << 16;
        den = edge_v * sf;
        i = num / den;
        if (classic_q)
        begin
            anchor = 65536 + sf * p;
            if (nu_v == edge_v)
            begin
                res.xs = xs_tbl[0];
                res.rg = csti_pkg::REGION_TABLE;
            end
            else if ((nu_v << 16) <= edge_v * anchor)
            begin
                if (i > p - 1) i = p - 1;
                res.xs = xs_tbl[i];
                res.rg = csti_pkg::REGION_TABLE;
            end
            else
            begin
                res.xs = tail_scale(anchor, edge_v, nu_v, p);
                res.rg = csti_pkg::REGION_TAIL;
            end
        end
        else if (i < p - 1)
        begin
            r = num % den;
            f = 0;
            for (int k = 0; k < 24; k++)
            begin
                r = r << 1;
                f = f << 1;
                if (r >= den)
                begin
                    r = r - den;
                    f = f | 1;
                end
            end
            a = xs_tbl[i];
            b = xs_tbl[i + 1];
            res.xs = 32'((((64'd16777216 - f) * a) + (f * b) + 64'd8388608) >> 24);
            res.rg = csti_pkg::REGION_TABLE;
        end
        else
        begin
            res.xs = tail_scale(ratio_q, edge_v, nu_v, p);
            res.rg = csti_pkg::REGION_TAIL;
        end
        return res;
    endfunction

    // Predict on input transfers, check output transfers, track register writes
    always @(posedge clk)
    begin
        xs_result_t got, exp_r;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    csti_pkg::REG_STEP:    step_q <= cfg_data[15:0];
                    csti_pkg::REG_POINTS:  points_q <= cfg_data[7:0];
                    csti_pkg::REG_RATIO:   ratio_q <= cfg_data;
                    csti_pkg::REG_CLASSIC: classic_q <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                exp_r = predict_xs(xs_item_t'{1'b0, 2'b0, 24'b0, mode, entry_index,
                                              entry_value, edge_freq, query_freq});
                expected_xs.push_back(exp_r);
                region_hits[exp_r.rg]++;
            end
            if (out_valid && out_ready)
            begin
                got.xs = cross_section;
                got.rg = region;
                if (expected_xs.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result xs=%h region=%0d",
                                              got.xs, got.rg));
                end
                else
                begin
                    exp_r = expected_xs.pop_front();
                    if (got.xs !== exp_r.xs)
                        report_mismatch($sformatf("cross_section %h, want %h",
                                                  got.xs, exp_r.xs));
                    if (got.rg !== exp_r.rg)
                        report_mismatch($sformatf("region %0d, want %0d",
                                                  got.rg, exp_r.rg));
                end
            end
            if (expected_xs.size() == 0 && !in_valid && !(in_valid && in_ready))
                quiet_cycles <= quiet_cycles + 1;
            else
                quiet_cycles <= 0;
        end
    end

    // Driver: feed pending items and register writes at the falling edge
    always @(negedge clk)
    begin
        xs_item_t it;
        bit calm;
        bit v_n, we_n;
        calm = pending_items.size() < CALM_ITEMS;
        v_n = in_valid;
        we_n = 1'b0;
        if (rst_n && !(in_valid && !in_taken))
        begin
            v_n = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items[0];
                if (it.is_cfg)
                begin
                    // hold register writes until the pipeline has drained
                    if (quiet_cycles >= QUIET_GAP && expected_xs.size() == 0)
                    begin
                        void'(pending_items.pop_front());
                        we_n = 1'b1;
                        cfg_index <= it.cfg_idx;
                        cfg_data <= it.cfg_val;
                    end
                end
                else
                begin
                    void'(pending_items.pop_front());
                    v_n = 1'b1;
                    mode <= it.mode;
                    entry_index <= it.idx;
                    entry_value <= it.val;
                    edge_freq <= it.edge_f;
                    query_freq <= it.nu;
                    if (!calm && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 12);
                end
            end
        end
        in_valid <= v_n;
        cfg_we <= we_n;
    end

    // Receiver: random stall bursts on out_ready
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (pending_items.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
        end
    end

    task automatic push_cfg(input logic [1:0] idx, input logic [23:0] val);
        pending_items.push_back(xs_item_t'{1'b1, idx, val, csti_pkg::MODE_LOAD,
                                           7'd0, 32'd0, 32'd1, 32'd0});
    endtask

    task automatic push_load(input logic [6:0] idx, input logic [31:0] val);
        pending_items.push_back(xs_item_t'{1'b0, 2'b0, 24'b0, csti_pkg::MODE_LOAD,
                                           idx, val, $urandom(), $urandom()});
    endtask

    task automatic push_query(input logic [31:0] edge_v, input logic [31:0] nu_v);
        pending_items.push_back(xs_item_t'{1'b0, 2'b0, 24'b0, MODE_QUERY,
                                           7'($urandom_range(0, 127)),
                                           $urandom(), edge_v, nu_v});
    endtask

    // Query below or at the edge, anywhere, or near or beyond the current phase's table span
    task automatic push_random_query(input int span);
        longint unsigned e, n;
        int sel;
        sel = $urandom_range(0, 19);
        case ($urandom_range(0, 3))
            0: e = $urandom_range(1, 255);
            1: e = $urandom_range(1, 65535);
            2: e = $urandom();
            default: e = $urandom_range(1000, 1000000);
        endcase
        if (sel == 0)
            n = (e > 0) ? $urandom_range(0, 32'(e - 1)) : 0;
        else if (sel == 1)
            n = e;
        else if (sel == 2)
            n = $urandom();
        else
            n = e + ((e * $urandom_range(0, span)) >> 16);
        if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
        push_query(32'(e), 32'(n));
    endtask

    // Stimulus
    initial
    begin
        int span;
        logic [15:0] sf;
        logic [7:0]  pts;
        // Fill the whole table so no unwritten entry is ever read
        for (int k = 0; k < TBL_DEPTH; k++)
            push_load(7'(k), (k == 0) ? 32'h0 : (k == 127) ? 32'hFFFF_FFFF : $urandom());
        // Directed queries at reset settings
        push_query(32'd1000, 32'd999);
        push_query(32'd1000, 32'd1000);
        push_query(32'd0, 32'd0);
        push_query(32'd0, 32'd5);
        push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_query(32'd1, 32'hFFFF_FFFF);
        push_query(32'd100000, 32'd150000);
        push_query(32'd100000, 32'd1100000);
        // Smallest table, widest tail ratio: tail saturates
        push_cfg(csti_pkg::REG_STEP, 24'd1);
        push_cfg(csti_pkg::REG_POINTS, 24'd2);
        push_cfg(csti_pkg::REG_RATIO, 24'hFFFFFF);
        push_query(32'd1000, 32'd1001);
        push_query(32'd1, 32'd2);
        // Zero step, zero and oversize point counts, classic mode
        push_cfg(csti_pkg::REG_STEP, 24'd0);
        push_cfg(csti_pkg::REG_POINTS, 24'd0);
        push_cfg(csti_pkg::REG_CLASSIC, 24'd1);
        push_query(32'd70000, 32'd69999);
        push_query(32'd70000, 32'd70000);
        push_query(32'd70000, 32'd70001);
        push_query(32'd70000, 32'd90000);
        push_cfg(csti_pkg::REG_STEP, 24'hFFFF);
        push_cfg(csti_pkg::REG_POINTS, 24'd255);
        push_cfg(csti_pkg::REG_RATIO, 24'd65536);
        push_query(32'd1000, 32'd129000);
        push_query(32'd1000, 32'd200000);
        push_query(32'd1000, 32'd1000000);
        // Random phases, each with fresh settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: sf = 16'd1;
                1: sf = 16'hFFFF;
                2: sf = 16'd0;
                default: sf = 16'($urandom_range(1, 65535));
            endcase
            case (ph)
                0: pts = 8'd128;
                1: pts = 8'd2;
                2: pts = 8'd1;
                default: pts = 8'($urandom_range(0, 255));
            endcase
            push_cfg(csti_pkg::REG_STEP, {8'($urandom_range(0, 255)), sf});
            push_cfg(csti_pkg::REG_POINTS, {16'($urandom_range(0, 65535)), pts});
            push_cfg(csti_pkg::REG_RATIO, (ph == 1) ? 24'd65536 : (ph == 0) ? 24'hFFFFFF
                                          : 24'($urandom_range(65536, 16777215)));
            push_cfg(csti_pkg::REG_CLASSIC, {23'($urandom_range(0, 8388607)), ph[0]});
            span = ((sf == 0) ? 1 : sf) * ((pts < 2) ? 2 : (pts > 128) ? 128 : pts);
            span = span + span / 2 + 2;
            for (int n = 0; n < 125; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    push_load(7'($urandom_range(0, 127)), $urandom());
                else
                    push_random_query(span);
            end
        end
        stim_done = 1'b1;
    end

    // Reset, drain and verdict
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && pending_items.size() == 0);
        @(posedge clk);
        while (in_valid || expected_xs.size() != 0)
            @(posedge clk);
        repeat (QUIET_GAP) @(posedge clk);
        $display("Covered %0d loads and queries below edge %0d, table %0d, tail %0d",
                 region_hits[csti_pkg::REGION_LOAD], region_hits[csti_pkg::REGION_BELOW],
                 region_hits[csti_pkg::REGION_TABLE], region_hits[csti_pkg::REGION_TAIL]);
        $display("over twelve register settings; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d results outstanding", expected_xs.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
